[hdl/krst_pkg.sv]
// ----------------------------------------------------------------------------
// krst_pkg
// Shared codes, widths and control structs of the keyed stock table.
// ----------------------------------------------------------------------------
package krst_pkg;

    // Default sizing of the table.
    localparam int DEF_MAX_ENTRIES = 16;
    localparam int DEF_VALUE_BITS  = 16;

    // Fixed field widths of the transaction ports.
    localparam int ACT_W   = 3;
    localparam int KEY_W   = 16;
    localparam int FIELD_W = 16;
    localparam int STAT_W  = 2;
    localparam int TOTAL_W = 20;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_ADD     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SET     = 3'd1;
    localparam logic [ACT_W-1:0] ACT_CONSUME = 3'd2;
    localparam logic [ACT_W-1:0] ACT_TICK    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_QUERY   = 3'd4;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    // Per-field write enables into the entry store.
    typedef struct packed {
        logic key_we;
        logic cap_we;
        logic rate_we;
        logic stock_we;
    } wr_en_t;

    // Lookup flags produced for the entry under inspection.
    typedef struct packed {
        logic match;
        logic first;
        logic take;
    } hit_t;

endpackage

[hdl/krst_store.sv]
// ----------------------------------------------------------------------------
// krst_store
// Entry memories: key, capacity, regeneration and stock, one write port and
// one registered read port shared by all four arrays.
// ----------------------------------------------------------------------------
module krst_store #(
    parameter int DEPTH      = krst_pkg::DEF_MAX_ENTRIES,
    parameter int IDX_W      = 4,
    parameter int VALUE_BITS = krst_pkg::DEF_VALUE_BITS
) (
    input  logic                    clk,
    input  krst_pkg::wr_en_t        wr_en,
    input  logic [IDX_W-1:0]        wr_addr,
    input  logic [krst_pkg::KEY_W-1:0] wr_key,
    input  logic [VALUE_BITS-1:0]   wr_cap,
    input  logic [VALUE_BITS-1:0]   wr_rate,
    input  logic [VALUE_BITS-1:0]   wr_stock,
    input  logic [IDX_W-1:0]        rd_addr,
    output logic [krst_pkg::KEY_W-1:0] rd_key,
    output logic [VALUE_BITS-1:0]   rd_cap,
    output logic [VALUE_BITS-1:0]   rd_rate,
    output logic [VALUE_BITS-1:0]   rd_stock
);
    import krst_pkg::*;

    logic [KEY_W-1:0]      key_mem   [DEPTH];
    logic [VALUE_BITS-1:0] cap_mem   [DEPTH];
    logic [VALUE_BITS-1:0] rate_mem  [DEPTH];
    logic [VALUE_BITS-1:0] stock_mem [DEPTH];

    // Write port, one enable per field.
    always_ff @(posedge clk)
    begin
        if (wr_en.key_we)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        if (wr_en.cap_we)
        begin
            cap_mem[wr_addr] <= wr_cap;
        end
        if (wr_en.rate_we)
        begin
            rate_mem[wr_addr] <= wr_rate;
        end
        if (wr_en.stock_we)
        begin
            stock_mem[wr_addr] <= wr_stock;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_key   <= key_mem[rd_addr];
        rd_cap   <= cap_mem[rd_addr];
        rd_rate  <= rate_mem[rd_addr];
        rd_stock <= stock_mem[rd_addr];
    end

endmodule

[hdl/krst_entry_unit.sv]
// ----------------------------------------------------------------------------
// krst_entry_unit
// Shared update unit: one adder and one comparator that work out the new
// contents of the entry being visited for the current action.
// ----------------------------------------------------------------------------
module krst_entry_unit #(
    parameter int VALUE_BITS = krst_pkg::DEF_VALUE_BITS
) (
    input  logic [krst_pkg::ACT_W-1:0] action,
    input  logic [krst_pkg::KEY_W-1:0] key_req,
    input  logic [VALUE_BITS-1:0]      cap_req,
    input  logic [VALUE_BITS-1:0]      rate_req,
    input  logic [krst_pkg::KEY_W-1:0] entry_key,
    input  logic [VALUE_BITS-1:0]      entry_cap,
    input  logic [VALUE_BITS-1:0]      entry_rate,
    input  logic [VALUE_BITS-1:0]      entry_stock,
    input  logic                       found,
    input  logic                       consumed,
    output logic [VALUE_BITS-1:0]      post_cap,
    output logic [VALUE_BITS-1:0]      post_rate,
    output logic [VALUE_BITS-1:0]      post_stock,
    output krst_pkg::wr_en_t           we,
    output krst_pkg::hit_t             hit
);
    import krst_pkg::*;

    logic [VALUE_BITS-1:0] add_b;
    logic [VALUE_BITS:0]   sum;
    logic [VALUE_BITS:0]   cmp_a;
    logic [VALUE_BITS:0]   cmp_b;
    logic                  over;
    logic                  is_tick;

    // Key match and the first-match / consume qualifiers.
    always_comb
    begin
        hit.match = (entry_key == key_req);
        hit.first = hit.match & ~found;
        hit.take  = (action == ACT_CONSUME) & hit.match & (entry_stock != '0) & ~consumed;
    end

    // Shared adder: stock plus regeneration on tick, stock minus one otherwise.
    assign is_tick = (action == ACT_TICK);
    assign add_b   = is_tick ? entry_rate : {VALUE_BITS{1'b1}};
    assign sum     = {1'b0, entry_stock} + {1'b0, add_b};

    // Shared comparator: saturation on tick, clamp against the new capacity otherwise.
    assign cmp_a = is_tick ? sum : {1'b0, entry_stock};
    assign cmp_b = is_tick ? {1'b0, entry_cap} : {1'b0, cap_req};
    assign over  = (cmp_a > cmp_b);

    // New entry contents and write enables.
    always_comb
    begin
        post_cap   = entry_cap;
        post_rate  = entry_rate;
        post_stock = entry_stock;
        we         = '0;
        unique case (action)
            ACT_SET:
            begin
                if (hit.first)
                begin
                    post_cap   = cap_req;
                    post_rate  = rate_req;
                    post_stock = over ? cap_req : entry_stock;
                    we.cap_we   = 1'b1;
                    we.rate_we  = 1'b1;
                    we.stock_we = 1'b1;
                end
            end
            ACT_CONSUME:
            begin
                if (hit.take)
                begin
                    post_stock  = sum[VALUE_BITS-1:0];
                    we.stock_we = 1'b1;
                end
            end
            ACT_TICK:
            begin
                if (entry_rate != '0)
                begin
                    post_stock  = over ? entry_cap : sum[VALUE_BITS-1:0];
                    we.stock_we = 1'b1;
                end
            end
            default:
            begin
                post_stock = entry_stock;
            end
        endcase
    end

endmodule

[hdl/keyed_regenerating_stock_table_core.sv]
// ----------------------------------------------------------------------------
// keyed_regenerating_stock_table_core
// Table of keyed token buckets with add, set, consume, tick and query.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one request transaction:
//   action, cell_req, capacity and regen_rate. The output channel
//   (out_valid/out_ready) returns exactly one result transaction per request:
//   status, is_known_cell, has_stock, cell_stock and total_stock.
//   A request is handled by a sequencer that walks the stored entries in
//   order, one entry per cycle, through the single read port of the entry
//   memory and one shared add/compare unit. An add first appends the new
//   entry when the table has room. The result is registered when the sweep
//   ends and in_ready rises in the same cycle; a new request is taken only
//   once the last one is through, and the sweep over the memory sets the rate.
//   The result sits in an output register; when the receiver stalls, the
//   next request is still swept and its result waits until the register is
//   taken. Reset empties the table (entry count zero) and drops any pending
//   result; the memories themselves need no clearing.
// ----------------------------------------------------------------------------
module keyed_regenerating_stock_table_core #(
    parameter int MAX_ENTRIES = krst_pkg::DEF_MAX_ENTRIES,
    parameter int VALUE_BITS  = krst_pkg::DEF_VALUE_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [krst_pkg::ACT_W-1:0]     action,
    input  logic [krst_pkg::KEY_W-1:0]     cell_req,
    input  logic [krst_pkg::FIELD_W-1:0]   capacity,
    input  logic [krst_pkg::FIELD_W-1:0]   regen_rate,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [krst_pkg::STAT_W-1:0]    status,
    output logic                           is_known_cell,
    output logic                           has_stock,
    output logic [krst_pkg::FIELD_W-1:0]   cell_stock,
    output logic [krst_pkg::TOTAL_W-1:0]   total_stock
);
    import krst_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int SUM_W = ((VALUE_BITS > TOTAL_W) ? VALUE_BITS : TOTAL_W) + 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ADD   = 2'd1;
    localparam logic [1:0] S_SWEEP = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      issue_reg;
    logic                  proc_valid_reg;
    logic [IDX_W-1:0]      proc_idx_reg;

    logic [ACT_W-1:0]      act_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [VALUE_BITS-1:0] cap_reg;
    logic [VALUE_BITS-1:0] rate_reg;

    logic                  full_reg;
    logic                  found_reg;
    logic                  consumed_reg;
    logic                  stocked_reg;
    logic [FIELD_W-1:0]    cstock_reg;
    logic [TOTAL_W-1:0]    total_reg;
    logic [TOTAL_W-1:0]    total_next;
    logic [SUM_W-1:0]      total_sum;

    logic                  out_valid_reg;
    logic [STAT_W-1:0]     status_reg;
    logic [STAT_W-1:0]     status_next;
    logic                  known_out_reg;
    logic                  stock_out_reg;
    logic [FIELD_W-1:0]    cstock_out_reg;
    logic [TOTAL_W-1:0]    total_out_reg;

    logic                  in_fire;
    logic                  issue_more;
    logic                  sweep_done;
    logic                  out_free;
    logic                  is_tick;

    wr_en_t                wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [VALUE_BITS-1:0] wr_cap;
    logic [VALUE_BITS-1:0] wr_rate;
    logic [VALUE_BITS-1:0] wr_stock;

    logic [KEY_W-1:0]      rd_key;
    logic [VALUE_BITS-1:0] rd_cap;
    logic [VALUE_BITS-1:0] rd_rate;
    logic [VALUE_BITS-1:0] rd_stock;

    logic [VALUE_BITS-1:0] post_cap;
    logic [VALUE_BITS-1:0] post_rate;
    logic [VALUE_BITS-1:0] post_stock;
    wr_en_t                unit_we;
    hit_t                  hit;

    // Handshake qualifiers.
    assign in_ready   = (state_reg == S_IDLE);
    assign in_fire    = in_valid & in_ready;
    assign issue_more = (issue_reg != count_reg);
    assign sweep_done = ~issue_more & ~proc_valid_reg;
    assign out_free   = ~out_valid_reg | out_ready;
    assign is_tick    = (act_reg == ACT_TICK);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if ((action == ACT_ADD) && (count_reg != CNT_W'(MAX_ENTRIES)))
                    begin
                        state_next = S_ADD;
                    end
                    else
                    begin
                        state_next = S_SWEEP;
                    end
                end
            end
            S_ADD:
            begin
                state_next = S_SWEEP;
            end
            S_SWEEP:
            begin
                if (sweep_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            issue_reg      <= '0;
            proc_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            proc_valid_reg <= (state_reg == S_SWEEP) & issue_more;
            if (in_fire)
            begin
                issue_reg <= '0;
            end
            else if ((state_reg == S_SWEEP) && issue_more)
            begin
                issue_reg <= issue_reg + 1'b1;
            end
            if (state_reg == S_ADD)
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Request capture and the index of the entry under inspection.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            act_reg  <= action;
            key_reg  <= cell_req;
            cap_reg  <= VALUE_BITS'(capacity);
            rate_reg <= VALUE_BITS'(regen_rate);
        end
        proc_idx_reg <= issue_reg[IDX_W-1:0];
    end

    // Entry memories.
    krst_store #(
        .DEPTH      (MAX_ENTRIES),
        .IDX_W      (IDX_W),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_key   (key_reg),
        .wr_cap   (wr_cap),
        .wr_rate  (wr_rate),
        .wr_stock (wr_stock),
        .rd_addr  (issue_reg[IDX_W-1:0]),
        .rd_key   (rd_key),
        .rd_cap   (rd_cap),
        .rd_rate  (rd_rate),
        .rd_stock (rd_stock)
    );

    // Shared update unit.
    krst_entry_unit #(
        .VALUE_BITS (VALUE_BITS)
    ) u_unit (
        .action      (act_reg),
        .key_req     (key_reg),
        .cap_req     (cap_reg),
        .rate_req    (rate_reg),
        .entry_key   (rd_key),
        .entry_cap   (rd_cap),
        .entry_rate  (rd_rate),
        .entry_stock (rd_stock),
        .found       (found_reg),
        .consumed    (consumed_reg),
        .post_cap    (post_cap),
        .post_rate   (post_rate),
        .post_stock  (post_stock),
        .we          (unit_we),
        .hit         (hit)
    );

    // Write port: append on add, write back during the sweep.
    always_comb
    begin
        if (state_reg == S_ADD)
        begin
            wr_en    = '1;
            wr_addr  = count_reg[IDX_W-1:0];
            wr_cap   = cap_reg;
            wr_rate  = rate_reg;
            wr_stock = cap_reg;
        end
        else
        begin
            wr_en    = proc_valid_reg ? unit_we : '0;
            wr_addr  = proc_idx_reg;
            wr_cap   = post_cap;
            wr_rate  = post_rate;
            wr_stock = post_stock;
        end
    end

    // Saturating running total of the post-action stock.
    assign total_sum  = SUM_W'(total_reg) + SUM_W'(post_stock);
    assign total_next = (total_sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                        : total_sum[TOTAL_W-1:0];

    // Lookup and total accumulation across the sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg     <= 1'b0;
            found_reg    <= 1'b0;
            consumed_reg <= 1'b0;
            stocked_reg  <= 1'b0;
            cstock_reg   <= '0;
            total_reg    <= '0;
        end
        else if (in_fire)
        begin
            full_reg     <= (action == ACT_ADD) && (count_reg == CNT_W'(MAX_ENTRIES));
            found_reg    <= 1'b0;
            consumed_reg <= 1'b0;
            stocked_reg  <= 1'b0;
            cstock_reg   <= '0;
            total_reg    <= '0;
        end
        else if (proc_valid_reg)
        begin
            total_reg <= total_next;
            if (hit.match)
            begin
                found_reg <= 1'b1;
                if (post_stock != '0)
                begin
                    stocked_reg <= 1'b1;
                end
            end
            if (hit.first)
            begin
                cstock_reg <= FIELD_W'(post_stock);
            end
            if (hit.take)
            begin
                consumed_reg <= 1'b1;
            end
        end
    end

    // Result status per action.
    always_comb
    begin
        unique case (act_reg)
            ACT_ADD:     status_next = full_reg ? ST_FULL : ST_DONE;
            ACT_SET:     status_next = found_reg ? ST_DONE : ST_MISS;
            ACT_CONSUME: status_next = consumed_reg ? ST_DONE : ST_MISS;
            ACT_TICK:    status_next = ST_DONE;
            default:     status_next = found_reg ? ST_DONE : ST_MISS;
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_FIN) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_FIN) && out_free)
        begin
            status_reg     <= status_next;
            known_out_reg  <= found_reg & ~is_tick;
            stock_out_reg  <= stocked_reg & ~is_tick;
            cstock_out_reg <= is_tick ? '0 : cstock_reg;
            total_out_reg  <= total_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign is_known_cell = known_out_reg;
    assign has_stock     = stock_out_reg;
    assign cell_stock    = cstock_out_reg;
    assign total_stock   = total_out_reg;

endmodule

[tb/keyed_regenerating_stock_table_core_test.sv]
// ----------------------------------------------------------------------------
// keyed_regenerating_stock_table_core_test
// Self-checking testbench of the keyed token bucket table.
//
// A short directed sequence covers the empty table, duplicate keys, clamping,
// draining and regeneration. A long random sequence then fills the table and
// mixes every action over a small set of keys. A clocked driver sends
// requests with random gaps, and a clocked monitor stalls at random.
// An in-bench model of the table predicts each result when its request is
// accepted, and the monitor compares every result field by field.
// ----------------------------------------------------------------------------
module keyed_regenerating_stock_table_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import krst_pkg::*;

    localparam int TABLE_DEPTH = DEF_MAX_ENTRIES;
    localparam int RANDOM_REQUESTS = 1700;
    localparam int DRAIN_CYCLES = 40;
    localparam int RUN_LIMIT_NS = 20_000_000;

    // One request and one result, as the ports carry them.
    typedef struct packed {
        logic [ACT_W-1:0]   act;
        logic [KEY_W-1:0]   key;
        logic [FIELD_W-1:0] cap;
        logic [FIELD_W-1:0] rate;
    } stock_req_t;

    typedef struct packed {
        logic [STAT_W-1:0]  stat;
        logic               known;
        logic               stocked;
        logic [FIELD_W-1:0] cstock;
        logic [TOTAL_W-1:0] total;
    } stock_resp_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [ACT_W-1:0]     action = '0;
    logic [KEY_W-1:0]     cell_req = '0;
    logic [FIELD_W-1:0]   capacity = '0;
    logic [FIELD_W-1:0]   regen_rate = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [STAT_W-1:0]    status;
    logic                 is_known_cell;
    logic                 has_stock;
    logic [FIELD_W-1:0]   cell_stock;
    logic [TOTAL_W-1:0]   total_stock;

    // Requests waiting to be sent and results waiting to arrive.
    stock_req_t     request_queue[$];
    stock_resp_t    pending_results[$];
    logic [KEY_W-1:0] stored_keys[$];

    stock_req_t     current_req = '0;
    stock_req_t     staged_req;
    stock_resp_t    want;
    int unsigned    send_gap = 0;
    int unsigned    stall_left = 0;
    int             accepted_count = 0;
    int             result_count = 0;
    int             error_count = 0;

    // Shadow copy of the bucket table.
    int               table_count = 0;
    logic [KEY_W-1:0]   table_key [TABLE_DEPTH];
    logic [FIELD_W-1:0] table_cap [TABLE_DEPTH];
    logic [FIELD_W-1:0] table_rate [TABLE_DEPTH];
    logic [FIELD_W-1:0] table_stock [TABLE_DEPTH];

    keyed_regenerating_stock_table_core #(
        .MAX_ENTRIES (TABLE_DEPTH),
        .VALUE_BITS  (DEF_VALUE_BITS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .cell_req      (cell_req),
        .capacity      (capacity),
        .regen_rate    (regen_rate),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .is_known_cell (is_known_cell),
        .has_stock     (has_stock),
        .cell_stock    (cell_stock),
        .total_stock   (total_stock)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Index of the first bucket carrying the key, or -1.
    function automatic int first_entry(logic [KEY_W-1:0] key);
        int hit;
        hit = -1;
        for (int i = table_count - 1; i >= 0; i--)
        begin
            if (table_key[i] == key)
                hit = i;
        end
        return hit;
    endfunction

    // Applies one request to the shadow table and returns the result it causes.
    function automatic stock_resp_t apply_request(stock_req_t req);
        stock_resp_t      res;
        int               hit;
        logic             taken;
        logic [FIELD_W:0] raised;
        logic [TOTAL_W:0] sum;
        res = '0;
        res.stat = ST_DONE;
        taken = 1'b0;
        case (req.act)
            ACT_ADD:
            begin
                if (table_count < TABLE_DEPTH)
                begin
                    table_key[table_count] = req.key;
                    table_cap[table_count] = req.cap;
                    table_rate[table_count] = req.rate;
                    table_stock[table_count] = req.cap;
                    table_count++;
                end
                else
                    res.stat = ST_FULL;
            end
            ACT_SET:
            begin
                hit = first_entry(req.key);
                if (hit < 0)
                    res.stat = ST_MISS;
                else
                begin
                    table_cap[hit] = req.cap;
                    table_rate[hit] = req.rate;
                    if (table_stock[hit] > req.cap)
                        table_stock[hit] = req.cap;
                end
            end
            ACT_CONSUME:
            begin
                // Only the first bucket with the key and stock left gives a unit.
                res.stat = ST_MISS;
                for (int i = 0; i < table_count; i++)
                begin
                    if (!taken && table_key[i] == req.key && table_stock[i] != 0)
                    begin
                        table_stock[i] = table_stock[i] - 1'b1;
                        taken = 1'b1;
                        res.stat = ST_DONE;
                    end
                end
            end
            ACT_TICK:
            begin
                for (int i = 0; i < table_count; i++)
                begin
                    if (table_rate[i] != 0)
                    begin
                        raised = {1'b0, table_stock[i]} + {1'b0, table_rate[i]};
                        if (raised > {1'b0, table_cap[i]})
                            table_stock[i] = table_cap[i];
                        else
                            table_stock[i] = raised[FIELD_W-1:0];
                    end
                end
            end
            default:
            begin
            end
        endcase

        // Table-wide total, saturating.
        sum = '0;
        for (int i = 0; i < table_count; i++)
        begin
            sum = sum + table_stock[i];
            if (sum > TOTAL_MAX)
                sum = {1'b0, TOTAL_MAX};
        end
        res.total = sum[TOTAL_W-1:0];

        // Lookup of the requested key; a tick reports none.
        if (req.act != ACT_TICK)
        begin
            hit = first_entry(req.key);
            if (hit >= 0)
            begin
                res.known = 1'b1;
                res.cstock = table_stock[hit];
            end
            for (int i = 0; i < table_count; i++)
            begin
                if (table_key[i] == req.key && table_stock[i] != 0)
                    res.stocked = 1'b1;
            end
            if (req.act >= ACT_QUERY)
                res.stat = res.known ? ST_DONE : ST_MISS;
        end
        return res;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 88)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 16);
        else
            return $urandom_range(30, 80);
    endfunction

    task automatic report_error(string msg);
        $display("[%0t] ERROR: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(int idx, string name, int unsigned got, int unsigned exp_val);
        if (got != exp_val)
            report_error($sformatf("result %0d %s: got %0d, expected %0d",
                                   idx, name, got, exp_val));
    endtask

    task automatic push_req(logic [ACT_W-1:0] act, logic [KEY_W-1:0] key,
                            logic [FIELD_W-1:0] cap, logic [FIELD_W-1:0] rate);
        stock_req_t req;
        req.act = act;
        req.key = key;
        req.cap = cap;
        req.rate = rate;
        request_queue.push_back(req);
        if (act == ACT_ADD && stored_keys.size() < TABLE_DEPTH)
            stored_keys.push_back(key);
    endtask

    // Request driver: presents queued transactions with random gaps and
    // updates the prediction on each accepted one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action <= '0;
            cell_req <= '0;
            capacity <= '0;
            regen_rate <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                pending_results.push_back(apply_request(current_req));
                accepted_count <= accepted_count + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (request_queue.size() != 0)
                begin
                    staged_req = request_queue.pop_front();
                    current_req <= staged_req;
                    action <= staged_req.act;
                    cell_req <= staged_req.key;
                    capacity <= staged_req.cap;
                    regen_rate <= staged_req.rate;
                    in_valid <= 1'b1;
                    // Every fourth stretch of requests runs back to back.
                    send_gap <= ((accepted_count / 150) % 4 == 3) ? 0 : pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: stalls at random and checks each accepted transaction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                result_count <= result_count + 1;
                if (pending_results.size() == 0)
                    report_error($sformatf("result %0d arrived with none expected",
                                           result_count));
                else
                begin
                    want = pending_results.pop_front();
                    check_field(result_count, "status", 32'(status), 32'(want.stat));
                    check_field(result_count, "is_known_cell", 32'(is_known_cell),
                                32'(want.known));
                    check_field(result_count, "has_stock", 32'(has_stock),
                                32'(want.stocked));
                    check_field(result_count, "cell_stock", 32'(cell_stock),
                                32'(want.cstock));
                    check_field(result_count, "total_stock", 32'(total_stock),
                                32'(want.total));
                end
            end
            if (stall_left != 0)
            begin
                out_ready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if ((result_count / 170) % 4 != 1 && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                stall_left <= pick_gap();
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int unsigned        roll;
        logic [ACT_W-1:0]   act;
        logic [KEY_W-1:0]   key;
        logic [FIELD_W-1:0] cap;
        logic [FIELD_W-1:0] rate;

        // Empty table: every lookup misses and a tick does nothing.
        push_req(ACT_QUERY, 16'h0000, 16'h0000, 16'h0000);
        push_req(ACT_CONSUME, 16'h0000, 16'hFFFF, 16'hFFFF);
        push_req(ACT_SET, 16'h0000, 16'h0005, 16'h0001);
        push_req(ACT_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF);

        // Extreme values, then a duplicated key.
        push_req(ACT_ADD, 16'h0000, 16'hFFFF, 16'h0000);
        push_req(ACT_ADD, 16'hFFFF, 16'h0000, 16'hFFFF);
        push_req(ACT_ADD, 16'h1234, 16'h0003, 16'h0001);
        push_req(ACT_ADD, 16'h1234, 16'h000A, 16'hFFFF);

        // Drain the first duplicate so the second one supplies the stock.
        repeat (4)
            push_req(ACT_CONSUME, 16'h1234, 16'h5A5A, 16'hA5A5);

        // A tick raises one bucket by one and saturates the two others that regenerate.
        push_req(ACT_TICK, 16'h0000, 16'h0000, 16'h0000);

        // Lowering the capacity clamps the stock.
        push_req(ACT_SET, 16'h1234, 16'h0000, 16'h0002);
        push_req(ACT_CONSUME, 16'hFFFF, 16'h0000, 16'h0000);
        push_req(ACT_SET, 16'h0000, 16'h0064, 16'h0007);

        // Unused action codes behave as a query.
        push_req(ACT_QUERY + 3'd1, 16'h0000, 16'hFFFF, 16'h0000);
        push_req(ACT_QUERY + 3'd2, 16'hBEEF, 16'h0000, 16'hFFFF);
        push_req(ACT_QUERY + 3'd3, 16'hFFFF, 16'h1111, 16'h2222);
        push_req(ACT_CONSUME, 16'hBEEF, 16'h0000, 16'h0000);

        // Random mix over a small key set; the table fills early and stays full.
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 12)
                act = ACT_ADD;
            else if (roll < 24)
                act = ACT_SET;
            else if (roll < 58)
                act = ACT_CONSUME;
            else if (roll < 76)
                act = ACT_TICK;
            else if (roll < 90)
                act = ACT_QUERY;
            else
                act = ACT_QUERY + 3'($urandom_range(1, 3));

            roll = $urandom_range(0, 99);
            if (roll < 65 && stored_keys.size() != 0)
                key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
            else if (roll < 88)
                key = 16'h0A50 + 16'($urandom_range(0, 5));
            else
                key = 16'($urandom);

            if (act == ACT_ADD || act == ACT_SET)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 60)
                    cap = 16'($urandom_range(0, 12));
                else if (roll < 85)
                    cap = 16'($urandom_range(0, 1000));
                else if (roll < 95)
                    cap = 16'($urandom);
                else
                    cap = 16'hFFFF;
                roll = $urandom_range(0, 99);
                if (roll < 30)
                    rate = '0;
                else if (roll < 70)
                    rate = 16'($urandom_range(1, 3));
                else if (roll < 90)
                    rate = 16'($urandom);
                else
                    rate = 16'hFFFF;
            end
            else
            begin
                cap = 16'($urandom);
                rate = 16'($urandom);
            end
            push_req(act, key, cap, rate);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (request_queue.size() != 0 || in_valid || pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("[%0t] ERROR: run did not finish, %0d requests accepted, %0d results",
                 $realtime, accepted_count, result_count);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[keyed_regenerating_stock_table_core.f]
hdl/krst_pkg.sv
hdl/krst_store.sv
hdl/krst_entry_unit.sv
hdl/keyed_regenerating_stock_table_core.sv
tb/keyed_regenerating_stock_table_core_test.sv
